// ----- rtl/core/anf_pkg.sv -----
package anf_pkg;

  // filter sizes
  localparam int MAX_AR_ORDER = 8;
  localparam int MAX_MA_ORDER = 8;
  localparam int MAX_TAPS     = (MAX_AR_ORDER > MAX_MA_ORDER) ? MAX_AR_ORDER : MAX_MA_ORDER;

  // counter and index widths
  localparam int TAP_W    = $clog2(MAX_TAPS + 1);
  localparam int AR_IW    = (MAX_AR_ORDER > 1) ? $clog2(MAX_AR_ORDER) : 1;
  localparam int MA_IW    = (MAX_MA_ORDER > 1) ? $clog2(MAX_MA_ORDER) : 1;
  localparam int ACOEF_IW = $clog2(MAX_AR_ORDER + 1);
  localparam int BCOEF_IW = $clog2(MAX_MA_ORDER + 1);

  // field widths
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 4;
  localparam int ORDER_W = 4;
  localparam int COEF_W  = 24;
  localparam int X_W     = 16;
  localparam int Y_W     = 32;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 24;

  // datapath widths
  localparam int MUL_A_W  = COEF_W;
  localparam int MUL_B_W  = 33;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 64;
  localparam int MID_W    = 40;
  localparam int MID_LO_W = 20;

  // rounding and saturation constants
  localparam int ROUND_SHIFT = 19;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd1 <<< (ROUND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] MID_MAX = (64'sd1 <<< (MID_W - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] MID_MIN = -(64'sd1 <<< (MID_W - 1));
  localparam logic signed [ACC_W-1:0] Y_MAX   = (64'sd1 <<< (Y_W - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] Y_MIN   = -(64'sd1 <<< (Y_W - 1));

  localparam logic signed [COEF_W-1:0] LEAD_RECIP_RESET = 24'sd524288;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_AR_ORDER   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MA_ORDER   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LEAD_RECIP = 2'd2;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_B = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_FILTER = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // product alignment before accumulation
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_4    = 2'd1,
    SH_20   = 2'd2
  } shift_t;

  // control word to the multiply-accumulate unit
  typedef struct packed {
    logic   issue;
    logic   clear;
    logic   neg;
    shift_t shift;
  } mac_ctl_t;

endpackage

// ----- rtl/core/anf_sample_if.sv -----
interface anf_sample_if import anf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [X_W-1:0]    excitation;

  modport source (output valid, op, coef_index, coef_value, excitation, input ready);
  modport sink (input valid, op, coef_index, coef_value, excitation, output ready);
endinterface

// ----- rtl/core/anf_result_if.sv -----
interface anf_result_if import anf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic signed [Y_W-1:0] filtered;
  logic                  saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink (input valid, filtered, saturated, output ready);
endinterface

// ----- rtl/core/anf_cfg_if.sv -----
interface anf_cfg_if import anf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/anf_mac.sv -----
module anf_mac import anf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  mac_ctl_t                  ctl,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [ACC_W-1:0]   acc
);

  mac_ctl_t                  ctl_q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   base;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
    prod <= op_a * op_b;
  end

  // align the product
  always_comb begin
    term = ACC_W'(prod);
    case (ctl_q.shift)
      SH_4:    term = ACC_W'(prod) <<< 4;
      SH_20:   term = ACC_W'(prod) <<< 20;
      default: term = ACC_W'(prod);
    endcase
    base = ctl_q.clear ? '0 : acc;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl_q.issue) begin
      acc <= ctl_q.neg ? (base - term) : (base + term);
    end
  end

endmodule

// ----- rtl/core/arma_noise_filter.sv -----
// ARMA noise filter, direct form, one shared multiply-accumulate unit.
// sample channel: op selects loading a numerator coefficient, loading a
// denominator coefficient, filtering one excitation sample, or nothing.
// Loads take one beat and give no result. A filter beat gives one result
// beat on the result channel (filtered output Q15.16 and a clip flag).
// cfg channel: always ready; index 0 ar_order, 1 input_order, 2 lead_reciprocal.
// Write it only while no sample is in flight.
// A filter sample runs the numerator taps, the denominator taps, a drain
// step, rounding, two normalizing passes, a wait and a finish step (na, nb
// the orders, capped at 8); sample ready returns with the result valid.
// The single multiplier takes one tap per cycle, then two passes for the
// normalizing product. A load leaves the sample side ready.
// The result sits in an output register: a new sample is taken while it
// waits, and the next sample stalls at its last step until the receiver
// takes the previous result.
// Reset clears both history lines, the orders and the output valid, and sets
// lead_reciprocal to 1.0; coefficients must be loaded before they are used.
module arma_noise_filter import anf_pkg::*; (
  input logic           clk,
  input logic           rst,
  anf_sample_if.sink    sample,
  anf_result_if.source  result,
  anf_cfg_if.sink       cfg
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAP_B,
    S_TAP_A,
    S_DRAIN,
    S_ROUND,
    S_NORM_LO,
    S_NORM_HI,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t                    state;
  logic [ORDER_W-1:0]        ar_order;
  logic [ORDER_W-1:0]        input_order;
  logic signed [COEF_W-1:0]  lead_reciprocal;

  logic signed [COEF_W-1:0]  bcoef [MAX_MA_ORDER+1];
  logic signed [COEF_W-1:0]  acoef [MAX_AR_ORDER+1];
  logic signed [X_W-1:0]     ih [MAX_MA_ORDER];
  logic signed [Y_W-1:0]     oh [MAX_AR_ORDER];

  logic [TAP_W-1:0]          cnt;
  logic [TAP_W-1:0]          na;
  logic [TAP_W-1:0]          nb;
  logic [TAP_W-1:0]          na_next;
  logic [TAP_W-1:0]          nb_next;
  logic [TAP_W-1:0]          cnt_prev;
  logic signed [X_W-1:0]     x_q;
  logic signed [MID_W-1:0]   mid;
  logic                      sat_mid;

  logic                      out_valid;
  logic signed [Y_W-1:0]     out_filtered;
  logic                      out_saturated;

  mac_ctl_t                  ctl;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_half;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [MID_W-1:0]   mid_next;
  logic                      mid_clip;
  logic signed [Y_W-1:0]     y_next;
  logic                      y_clip;
  logic                      in_beat;
  logic                      out_free;

  anf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // handshakes
  assign sample.ready     = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_valid;
  assign result.filtered  = out_filtered;
  assign result.saturated = out_saturated;
  assign in_beat          = sample.valid && sample.ready;
  assign out_free         = !out_valid || result.ready;

  // orders capped at the history depth
  assign na_next  = (int'(ar_order) > MAX_AR_ORDER) ? TAP_W'(MAX_AR_ORDER) : TAP_W'(ar_order);
  assign nb_next  = (int'(input_order) > MAX_MA_ORDER) ? TAP_W'(MAX_MA_ORDER)
                                                       : TAP_W'(input_order);
  assign cnt_prev = cnt - 1'b1;

  // operand select for the shared unit
  always_comb begin
    ctl  = '0;
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_TAP_B: begin
        ctl.issue = 1'b1;
        ctl.clear = (cnt == '0);
        ctl.shift = SH_4;
        op_a      = bcoef[BCOEF_IW'(cnt)];
        op_b      = (cnt == '0) ? MUL_B_W'(x_q) : MUL_B_W'(ih[MA_IW'(cnt_prev)]);
      end
      S_TAP_A: begin
        ctl.issue = 1'b1;
        ctl.neg   = 1'b1;
        op_a      = acoef[ACOEF_IW'(cnt)];
        op_b      = MUL_B_W'(oh[AR_IW'(cnt_prev)]);
      end
      S_NORM_LO: begin
        ctl.issue = 1'b1;
        ctl.clear = 1'b1;
        op_a      = lead_reciprocal;
        op_b      = MUL_B_W'(mid[MID_LO_W-1:0]);
      end
      S_NORM_HI: begin
        ctl.issue = 1'b1;
        ctl.shift = SH_20;
        op_a      = lead_reciprocal;
        op_b      = MUL_B_W'(signed'(mid[MID_W-1:MID_LO_W]));
      end
      default: begin
        ctl.issue = 1'b0;
      end
    endcase
  end

  // round to 16 fraction bits and clip, shared by both passes
  always_comb begin
    acc_half = acc + ROUND_HALF;
    acc_rnd  = acc_half >>> ROUND_SHIFT;
    mid_clip = (acc_rnd > MID_MAX) || (acc_rnd < MID_MIN);
    y_clip   = (acc_rnd > Y_MAX) || (acc_rnd < Y_MIN);
    if (acc_rnd > MID_MAX) begin
      mid_next = MID_W'(MID_MAX);
    end else if (acc_rnd < MID_MIN) begin
      mid_next = MID_W'(MID_MIN);
    end else begin
      mid_next = MID_W'(acc_rnd);
    end
    if (acc_rnd > Y_MAX) begin
      y_next = Y_W'(Y_MAX);
    end else if (acc_rnd < Y_MIN) begin
      y_next = Y_W'(Y_MIN);
    end else begin
      y_next = Y_W'(acc_rnd);
    end
  end

  // coefficient stores
  always_ff @(posedge clk) begin
    if (in_beat && sample.op == OP_LOAD_B && int'(sample.coef_index) <= MAX_MA_ORDER) begin
      bcoef[BCOEF_IW'(sample.coef_index)] <= sample.coef_value;
    end
    if (in_beat && sample.op == OP_LOAD_A && int'(sample.coef_index) <= MAX_AR_ORDER) begin
      acoef[ACOEF_IW'(sample.coef_index)] <= sample.coef_value;
    end
  end

  // sequencer, configuration, histories and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ar_order        <= '0;
      input_order     <= '0;
      lead_reciprocal <= LEAD_RECIP_RESET;
      cnt             <= '0;
      na              <= '0;
      nb              <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < MAX_MA_ORDER; i++) begin
        ih[i] <= '0;
      end
      for (int i = 0; i < MAX_AR_ORDER; i++) begin
        oh[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_AR_ORDER:   ar_order <= cfg.data[ORDER_W-1:0];
          CFG_MA_ORDER:   input_order <= cfg.data[ORDER_W-1:0];
          CFG_LEAD_RECIP: lead_reciprocal <= signed'(cfg.data[COEF_W-1:0]);
          default:        ar_order <= ar_order;
        endcase
      end

      // result valid: loaded at the last step, cleared when taken
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_beat && sample.op == OP_FILTER) begin
            x_q   <= sample.excitation;
            na    <= na_next;
            nb    <= nb_next;
            cnt   <= '0;
            state <= S_TAP_B;
          end
        end
        S_TAP_B: begin
          if (cnt == nb) begin
            if (na != '0) begin
              cnt   <= TAP_W'(1);
              state <= S_TAP_A;
            end else begin
              state <= S_DRAIN;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TAP_A: begin
          if (cnt == na) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          mid     <= mid_next;
          sat_mid <= mid_clip;
          state   <= S_NORM_LO;
        end
        S_NORM_LO: begin
          state <= S_NORM_HI;
        end
        S_NORM_HI: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_filtered  <= y_next;
            out_saturated <= sat_mid || y_clip;
            // shift both history lines within the used length
            if (na != '0) begin
              oh[0] <= y_next;
            end
            for (int i = 1; i < MAX_AR_ORDER; i++) begin
              if (i < int'(na)) begin
                oh[i] <= oh[i-1];
              end
            end
            if (nb != '0) begin
              ih[0] <= x_q;
            end
            for (int i = 1; i < MAX_MA_ORDER; i++) begin
              if (i < int'(nb)) begin
                ih[i] <= ih[i-1];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/anf_checker.sv -----
module anf_checker import anf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [OP_W-1:0]       in_op,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [Y_W-1:0] out_filtered
);

  // a waiting result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a waiting result beat keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_filtered))
    else $error("result value changed while stalled");

  // a filter beat keeps the sample side busy
  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op == OP_FILTER |=> !in_ready)
    else $error("sample taken while a filter beat is in work");

  // loads and empty beats leave the sample side ready
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op != OP_FILTER |=> in_ready)
    else $error("load beat held the sample side");

  // no result rises right after a load
  a_no_load_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op != OP_FILTER && !out_valid |=> !out_valid)
    else $error("result beat appeared after a load");

endmodule

bind arma_noise_filter anf_checker u_anf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .in_op        (sample.op),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_filtered (result.filtered)
);

// ----- sim/arma_noise_filter_tb.sv -----
module arma_noise_filter_tb;
  import anf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * MAX_TAPS + 16;
  localparam int RANDOM_ITEMS   = 500;
  localparam int NUM_PHASES     = 8;

  localparam longint MID_HI = (64'sd1 <<< 39) - 64'sd1;
  localparam longint MID_LO = -(64'sd1 <<< 39);
  localparam longint OUT_HI = (64'sd1 <<< 31) - 64'sd1;
  localparam longint OUT_LO = -(64'sd1 <<< 31);

  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7fffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0] ONE_Q19  = 24'sd524288;
  localparam logic signed [X_W-1:0]    X_MAX    = 16'sh7fff;
  localparam logic signed [X_W-1:0]    X_MIN    = 16'sh8000;

  typedef struct {
    logic signed [Y_W-1:0] filtered;
    logic                  saturated;
  } filt_out_t;

  logic clk;
  logic rst;

  anf_sample_if sample_ch();
  anf_result_if result_ch();
  anf_cfg_if    cfg_ch();

  arma_noise_filter DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // predictor copy of registers, coefficients and history lines
  logic [ORDER_W-1:0]       ar_taps;
  logic [ORDER_W-1:0]       ma_taps;
  logic signed [COEF_W-1:0] lead_recip;
  logic signed [COEF_W-1:0] num_coef [0:MAX_MA_ORDER];
  logic signed [COEF_W-1:0] den_coef [0:MAX_AR_ORDER];
  logic signed [Y_W-1:0]    out_hist [0:MAX_AR_ORDER-1];
  logic signed [X_W-1:0]    in_hist  [0:MAX_MA_ORDER-1];

  filt_out_t filt_expect_q[$];
  filt_out_t want;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt    = 0;
  int results_checked = 0;
  int sat_results     = 0;
  int loads_sent      = 0;
  int idle_cycles     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("MISMATCH at %0t: %s", $time, what);
  endfunction

  // round a value with 35 fraction bits down to 16
  function automatic longint round_q19(longint v);
    return (v + (64'sd1 <<< 18)) >>> 19;
  endfunction

  // update predictor state for one accepted beat, queue the result of a filter beat
  function automatic void predict_arma(op_t op, logic [CIDX_W-1:0] idx,
                                       logic signed [COEF_W-1:0] cval,
                                       logic signed [X_W-1:0] x);
    int        na;
    int        nb;
    int        k;
    longint    acc;
    longint    y;
    logic      clipped;
    filt_out_t r;
    na = (ar_taps > MAX_AR_ORDER) ? MAX_AR_ORDER : int'(ar_taps);
    nb = (ma_taps > MAX_MA_ORDER) ? MAX_MA_ORDER : int'(ma_taps);
    case (op)
      OP_LOAD_B: if (idx <= MAX_MA_ORDER) num_coef[idx] = cval;
      OP_LOAD_A: if (idx <= MAX_AR_ORDER) den_coef[idx] = cval;
      OP_FILTER: begin
        clipped = 1'b0;
        acc = longint'(num_coef[0]) * longint'(x) * 16;
        for (k = 1; k <= nb; k++)
          acc += longint'(num_coef[k]) * longint'(in_hist[k-1]) * 16;
        for (k = 1; k <= na; k++)
          acc -= longint'(den_coef[k]) * longint'(out_hist[k-1]);
        acc = round_q19(acc);
        if (acc > MID_HI) begin
          acc = MID_HI;
          clipped = 1'b1;
        end else if (acc < MID_LO) begin
          acc = MID_LO;
          clipped = 1'b1;
        end
        y = round_q19(acc * longint'(lead_recip));
        if (y > OUT_HI) begin
          y = OUT_HI;
          clipped = 1'b1;
        end else if (y < OUT_LO) begin
          y = OUT_LO;
          clipped = 1'b1;
        end
        // shift only within the used length
        for (k = na; k > 1; k--) out_hist[k-1] = out_hist[k-2];
        if (na > 0) out_hist[0] = y[Y_W-1:0];
        for (k = nb; k > 1; k--) in_hist[k-1] = in_hist[k-2];
        if (nb > 0) in_hist[0] = x;
        r.filtered  = y[Y_W-1:0];
        r.saturated = clipped;
        filt_expect_q = {filt_expect_q, r};
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(int span_bits);
    logic signed [COEF_W-1:0] v;
    v = COEF_W'($urandom);
    case ($urandom_range(19))
      0: return COEF_MAX;
      1: return COEF_MIN;
      default: return v >>> (COEF_W - span_bits);
    endcase
  endfunction

  function automatic logic signed [X_W-1:0] rand_excitation();
    case ($urandom_range(15))
      0: return X_MAX;
      1: return X_MIN;
      default: return X_W'($urandom);
    endcase
  endfunction

  // send one beat on the sample channel, with random gaps ahead of it
  task automatic send_item(op_t op, logic [CIDX_W-1:0] idx,
                           logic signed [COEF_W-1:0] cval, logic signed [X_W-1:0] x);
    while ($urandom_range(99) < send_gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.op         <= op;
    sample_ch.coef_index <= idx;
    sample_ch.coef_value <= cval;
    sample_ch.excitation <= x;
    do @(posedge clk); while (!sample_ch.ready);
    predict_arma(op, idx, cval, x);
    if (op == OP_LOAD_A || op == OP_LOAD_B) loads_sent++;
  endtask

  task automatic send_filter(logic signed [X_W-1:0] x);
    send_item(OP_FILTER, CIDX_W'($urandom), COEF_W'($urandom), x);
  endtask

  // one register write beat
  task automatic write_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      CFG_AR_ORDER:   ar_taps    = data[ORDER_W-1:0];
      CFG_MA_ORDER:   ma_taps    = data[ORDER_W-1:0];
      CFG_LEAD_RECIP: lead_recip = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // order registers use the low bits only, upper bits get noise
  task automatic write_settings(int ar, int ma, logic signed [COEF_W-1:0] recip);
    write_reg(CFG_AR_ORDER, {(CFG_DW-ORDER_W)'($urandom), ORDER_W'(ar)});
    write_reg(CFG_MA_ORDER, {(CFG_DW-ORDER_W)'($urandom), ORDER_W'(ma)});
    write_reg(CFG_LEAD_RECIP, recip);
  endtask

  // drain all results, then let a trailing load or filter settle
  task automatic wait_until_idle();
    sample_ch.valid <= 1'b0;
    while (filt_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 71; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 71; end
      default: begin send_gap_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // load every coefficient, then filter at the reset settings
  task automatic test_coef_load();
    int k;
    for (k = 0; k <= MAX_MA_ORDER; k++)
      send_item(OP_LOAD_B, CIDX_W'(k),
                (k == 0) ? COEF_MAX : (k == 1) ? COEF_MIN : rand_coef(20),
                rand_excitation());
    for (k = 0; k <= MAX_AR_ORDER; k++)
      send_item(OP_LOAD_A, CIDX_W'(k),
                (k == 0) ? COEF_MIN : (k == 1) ? COEF_MAX : rand_coef(20),
                rand_excitation());
    // out-of-range indexes must not disturb b[0] or a[8]
    send_item(OP_LOAD_B, CIDX_W'(MAX_MA_ORDER + 1), COEF_MIN, X_MIN);
    send_item(OP_LOAD_A, 4'hf, COEF_MAX, X_MAX);
    send_item(OP_NONE, 4'hf, COEF_MIN, X_MIN);
    send_filter(X_MAX);
    send_filter(X_MIN);
  endtask

  // runaway feedback drives the output into clipping
  task automatic test_saturation();
    int k;
    wait_until_idle();
    write_settings(1, 15, COEF_MAX);
    send_item(OP_LOAD_A, 4'd1, COEF_MIN, X_MIN);
    for (k = 0; k < 4; k++) send_filter(X_MAX);
    wait_until_idle();
    write_reg(CFG_LEAD_RECIP, COEF_MIN);
    send_filter(X_MIN);
    send_filter(16'sd0);
  endtask

  // filter streams with random reloads, one setting and idling mode per phase
  task automatic test_random_traffic();
    int                       phase;
    int                       n;
    int                       roll;
    int                       ar;
    int                       ma;
    int                       span;
    logic signed [COEF_W-1:0] recip;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_until_idle();
      case (phase)
        0: begin ar = MAX_AR_ORDER; ma = MAX_MA_ORDER; recip = ONE_Q19; end
        1: begin ar = 0;  ma = 0;  recip = COEF_MIN; end
        2: begin ar = 15; ma = 15; recip = COEF_MAX; end
        3: begin ar = 0;  ma = MAX_MA_ORDER; recip = '0; end
        4: begin ar = MAX_AR_ORDER; ma = 0; recip = rand_coef(20); end
        default: begin
          ar    = $urandom_range(15);
          ma    = $urandom_range(15);
          recip = rand_coef($urandom_range(16, COEF_W));
        end
      endcase
      write_settings(ar, ma, recip);
      set_idling(phase % 4);
      span = $urandom_range(16, COEF_W);
      for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        roll = $urandom_range(99);
        if (roll < 72)
          send_filter(rand_excitation());
        else if (roll < 90)
          send_item(op_t'(roll[0] ? OP_LOAD_A : OP_LOAD_B),
                    CIDX_W'($urandom_range(MAX_MA_ORDER)), rand_coef(span), X_W'($urandom));
        else if (roll < 96)
          send_item(op_t'(roll[0] ? OP_LOAD_A : OP_LOAD_B),
                    CIDX_W'($urandom_range(15, MAX_MA_ORDER + 1)), rand_coef(span),
                    X_W'($urandom));
        else
          send_item(OP_NONE, CIDX_W'($urandom), COEF_W'($urandom), X_W'($urandom));
      end
    end
    set_idling(0);
  endtask

  // result side: random stall, compare each beat with the oldest prediction
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (filt_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result filtered=%0d saturated=%0b",
                                  result_ch.filtered, result_ch.saturated));
      end else begin
        want = filt_expect_q.pop_front();
        results_checked++;
        if (want.saturated) sat_results++;
        if (result_ch.filtered !== want.filtered)
          report_mismatch($sformatf("filtered expected %0d got %0d",
                                    want.filtered, result_ch.filtered));
        if (result_ch.saturated !== want.saturated)
          report_mismatch($sformatf("saturated expected %0b got %0b",
                                    want.saturated, result_ch.saturated));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, filt_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    rst                  = 1'b1;
    sample_ch.valid      = 1'b0;
    sample_ch.op         = OP_NONE;
    sample_ch.coef_index = '0;
    sample_ch.coef_value = '0;
    sample_ch.excitation = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_AR_ORDER;
    cfg_ch.data          = '0;
    ar_taps              = '0;
    ma_taps              = '0;
    lead_recip           = LEAD_RECIP_RESET;
    foreach (out_hist[i]) out_hist[i] = '0;
    foreach (in_hist[i]) in_hist[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_coef_load();
    test_saturation();
    test_random_traffic();
    wait_until_idle();

    if (filt_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", filt_expect_q.size()));
    $display("checked %0d filter results (%0d clipped), %0d coefficient loads sent",
             results_checked, sat_results, loads_sent);
    $display("%0d random phases over orders 0..15 and extreme reciprocals, %0d mismatches",
             NUM_PHASES, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
